>>> design/dfb_pkg.sv
package dfb_pkg;

   localparam int COORD_W   = 12;
   localparam int DEPTH_W   = 16;
   localparam int REG_W     = 20;
   localparam int FRAC_W    = 8;
   localparam int SLOPE_FRAC = 16;
   localparam int SLOPE_W   = 31;
   localparam int NUM_W     = REG_W + SLOPE_FRAC;
   localparam int ROOT_W    = 32;
   localparam int SQ_W      = 2 * ROOT_W;
   localparam int PROD_W    = DEPTH_W + SLOPE_W;
   localparam int QUO_W     = 24;
   localparam int DIV_W     = PROD_W + FRAC_W + 1;
   localparam int PX_W      = 25;
   localparam int PZ_W      = 24;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 80;
   localparam int CSR_IDX_W = 3;

   localparam logic [REG_W-1:0] FOCAL_X_RESET  = 20'd131072;
   localparam logic [REG_W-1:0] FOCAL_Y_RESET  = 20'd131072;
   localparam logic [REG_W-1:0] CENTER_X_RESET = 20'd81920;
   localparam logic [REG_W-1:0] CENTER_Y_RESET = 20'd61440;
   localparam logic [SLOPE_W-1:0] SLOPE_MAX    = {SLOPE_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FOCAL_X  = 3'd0,
      CSR_FOCAL_Y  = 3'd1,
      CSR_CENTER_X = 3'd2,
      CSR_CENTER_Y = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic               neg;
      logic               sat;
      logic [NUM_W-1:0]   rem;
      logic [SLOPE_W-1:0] quo;
   } slope_lane_type;

   typedef struct packed {
      logic               valid;
      logic [DEPTH_W-1:0] depth;
      logic [SLOPE_W-1:0] ux;
      logic [SLOPE_W-1:0] vy;
      logic               nx;
      logic               ny;
   } slope_out_type;

   typedef struct packed {
      logic               valid;
      logic [DEPTH_W-1:0] depth;
      logic [SLOPE_W-1:0] ux;
      logic [SLOPE_W-1:0] vy;
      logic               nx;
      logic               ny;
      logic [ROOT_W-1:0]  r;
   } root_out_type;

   typedef struct packed {
      logic                   valid;
      logic signed [PX_W-1:0] x;
      logic signed [PX_W-1:0] y;
      logic [PZ_W-1:0]        z;
   } point_type;

endpackage

>>> design/dfb_slope.sv
module dfb_slope
   import dfb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [COORD_W-1:0] pixel_col,
   input  logic [COORD_W-1:0] pixel_row,
   input  logic [DEPTH_W-1:0] depth,
   input  logic [REG_W-1:0]   focal_x,
   input  logic [REG_W-1:0]   focal_y,
   input  logic [REG_W-1:0]   center_x,
   input  logic [REG_W-1:0]   center_y,
   output slope_out_type      out
);

   localparam int STAGES = SLOPE_W + 1;
   localparam int WIDE   = REG_W + SLOPE_W + 1;

   slope_lane_type     lane_ff  [2][STAGES];
   slope_lane_type     lane_in  [2][STAGES];
   logic               valid_ff [STAGES];
   logic               valid_in [STAGES];
   logic [DEPTH_W-1:0] depth_ff [STAGES];
   logic [DEPTH_W-1:0] depth_in [STAGES];

   logic [REG_W-1:0]   focal_eff [2];
   logic [REG_W-1:0]   center    [2];
   logic [COORD_W-1:0] pix       [2];
   logic [REG_W-1:0]   pos;
   logic [REG_W-1:0]   mag;
   logic [WIDE-1:0]    trial;
   logic [SLOPE_W-1:0] slope_sel [2];

   always_comb begin
      focal_eff[0] = (focal_x == '0) ? REG_W'(1) : focal_x;
      focal_eff[1] = (focal_y == '0) ? REG_W'(1) : focal_y;
      center[0] = center_x;
      center[1] = center_y;
      pix[0] = pixel_col;
      pix[1] = pixel_row;
      pos = '0;
      mag = '0;
      trial = '0;
      valid_in[0] = in_valid;
      depth_in[0] = depth;
      for (int s = 1; s < STAGES; s++) begin
         valid_in[s] = valid_ff[s-1];
         depth_in[s] = depth_ff[s-1];
      end
      for (int l = 0; l < 2; l++) begin
         pos = {pix[l], {FRAC_W{1'b0}}};
         lane_in[l][0].neg = (pos < center[l]);
         if (pos >= center[l]) begin
            mag = pos - center[l];
         end else begin
            mag = center[l] - pos;
         end
         lane_in[l][0].sat = NUM_W'(mag) >= (NUM_W'(focal_eff[l]) << (SLOPE_W - SLOPE_FRAC));
         lane_in[l][0].rem = {mag, {SLOPE_FRAC{1'b0}}};
         lane_in[l][0].quo = '0;
         for (int s = 1; s < STAGES; s++) begin
            lane_in[l][s] = lane_ff[l][s-1];
            trial = WIDE'(focal_eff[l]) << (SLOPE_W - s);
            if (WIDE'(lane_ff[l][s-1].rem) >= trial) begin
               lane_in[l][s].rem = lane_ff[l][s-1].rem - trial[NUM_W-1:0];
               lane_in[l][s].quo[SLOPE_W-s] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES; s++) valid_ff[s] <= 1'b0;
      end else if (en) begin
         for (int s = 0; s < STAGES; s++) valid_ff[s] <= valid_in[s];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < STAGES; s++) begin
            depth_ff[s] <= depth_in[s];
            lane_ff[0][s] <= lane_in[0][s];
            lane_ff[1][s] <= lane_in[1][s];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         slope_sel[l] = lane_ff[l][STAGES-1].sat ? SLOPE_MAX : lane_ff[l][STAGES-1].quo;
      end
      out.valid = valid_ff[STAGES-1];
      out.depth = depth_ff[STAGES-1];
      out.ux = slope_sel[0];
      out.vy = slope_sel[1];
      out.nx = lane_ff[0][STAGES-1].neg && (slope_sel[0] != '0);
      out.ny = lane_ff[1][STAGES-1].neg && (slope_sel[1] != '0);
   end

endmodule

>>> design/dfb_root.sv
module dfb_root
   import dfb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  slope_out_type in,
   output root_out_type  out
);

   localparam int STAGES = ROOT_W + 2;

   slope_out_type     pass_ff [STAGES];
   slope_out_type     pass_in [STAGES];
   logic [SQ_W-1:0]   sqx_ff;
   logic [SQ_W-1:0]   sqy_ff;
   logic [SQ_W-1:0]   rem_ff  [STAGES];
   logic [SQ_W-1:0]   rem_in  [STAGES];
   logic [ROOT_W-1:0] root_ff [STAGES];
   logic [ROOT_W-1:0] root_in [STAGES];
   logic [SQ_W-1:0]   trial;

   always_comb begin
      trial = '0;
      pass_in[0] = in;
      rem_in[0] = '0;
      root_in[0] = '0;
      pass_in[1] = pass_ff[0];
      rem_in[1] = sqx_ff + sqy_ff + (SQ_W'(1) << (2 * SLOPE_FRAC));
      root_in[1] = '0;
      for (int s = 2; s < STAGES; s++) begin
         pass_in[s] = pass_ff[s-1];
         rem_in[s] = rem_ff[s-1];
         root_in[s] = root_ff[s-1];
         trial = (SQ_W'(root_ff[s-1]) << (STAGES - s))
               | (SQ_W'(1) << (2 * (STAGES - 1 - s)));
         if (rem_ff[s-1] >= trial) begin
            rem_in[s] = rem_ff[s-1] - trial;
            root_in[s][STAGES-1-s] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES; s++) pass_ff[s].valid <= 1'b0;
      end else if (en) begin
         for (int s = 0; s < STAGES; s++) pass_ff[s].valid <= pass_in[s].valid;
      end
      if (en) begin
         sqx_ff <= SQ_W'(in.ux * in.ux);
         sqy_ff <= SQ_W'(in.vy * in.vy);
         for (int s = 0; s < STAGES; s++) begin
            pass_ff[s].depth <= pass_in[s].depth;
            pass_ff[s].ux <= pass_in[s].ux;
            pass_ff[s].vy <= pass_in[s].vy;
            pass_ff[s].nx <= pass_in[s].nx;
            pass_ff[s].ny <= pass_in[s].ny;
            rem_ff[s] <= rem_in[s];
            root_ff[s] <= root_in[s];
         end
      end
   end

   always_comb begin
      out.valid = pass_ff[STAGES-1].valid;
      out.depth = pass_ff[STAGES-1].depth;
      out.ux = pass_ff[STAGES-1].ux;
      out.vy = pass_ff[STAGES-1].vy;
      out.nx = pass_ff[STAGES-1].nx;
      out.ny = pass_ff[STAGES-1].ny;
      out.r = root_ff[STAGES-1];
   end

endmodule

>>> design/dfb_scale.sv
module dfb_scale
   import dfb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  root_out_type in,
   output point_type    out
);

   localparam int STAGES = QUO_W + 2;

   logic              valid_ff [STAGES];
   logic              valid_in [STAGES];
   logic              nx_ff    [STAGES];
   logic              ny_ff    [STAGES];
   logic [ROOT_W-1:0] r_ff     [STAGES];
   logic [PROD_W-1:0] prodx_ff;
   logic [PROD_W-1:0] prody_ff;
   logic [DEPTH_W-1:0] depth_ff;
   logic [DIV_W-1:0]  rem_ff   [3][STAGES];
   logic [DIV_W-1:0]  rem_in   [3][STAGES];
   logic [QUO_W-1:0]  quo_ff   [3][STAGES];
   logic [QUO_W-1:0]  quo_in   [3][STAGES];
   logic [DIV_W-1:0]  half_r;
   logic [DIV_W-1:0]  trial;

   always_comb begin
      trial = '0;
      half_r = DIV_W'(r_ff[0] >> 1);
      valid_in[0] = in.valid;
      for (int l = 0; l < 3; l++) begin
         rem_in[l][0] = '0;
         quo_in[l][0] = '0;
         quo_in[l][1] = '0;
      end
      rem_in[0][1] = DIV_W'({prodx_ff, {FRAC_W{1'b0}}}) + half_r;
      rem_in[1][1] = DIV_W'({prody_ff, {FRAC_W{1'b0}}}) + half_r;
      rem_in[2][1] = DIV_W'({depth_ff, {PZ_W{1'b0}}}) + half_r;
      for (int s = 1; s < STAGES; s++) valid_in[s] = valid_ff[s-1];
      for (int s = 2; s < STAGES; s++) begin
         trial = DIV_W'(r_ff[s-1]) << (STAGES - 1 - s);
         for (int l = 0; l < 3; l++) begin
            rem_in[l][s] = rem_ff[l][s-1];
            quo_in[l][s] = quo_ff[l][s-1];
            if (rem_ff[l][s-1] >= trial) begin
               rem_in[l][s] = rem_ff[l][s-1] - trial;
               quo_in[l][s][STAGES-1-s] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES; s++) valid_ff[s] <= 1'b0;
      end else if (en) begin
         for (int s = 0; s < STAGES; s++) valid_ff[s] <= valid_in[s];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prodx_ff <= PROD_W'(in.depth * in.ux);
         prody_ff <= PROD_W'(in.depth * in.vy);
         depth_ff <= in.depth;
         nx_ff[0] <= in.nx;
         ny_ff[0] <= in.ny;
         r_ff[0] <= in.r;
         for (int s = 1; s < STAGES; s++) begin
            nx_ff[s] <= nx_ff[s-1];
            ny_ff[s] <= ny_ff[s-1];
            r_ff[s] <= r_ff[s-1];
         end
         for (int l = 0; l < 3; l++) begin
            for (int s = 0; s < STAGES; s++) begin
               rem_ff[l][s] <= rem_in[l][s];
               quo_ff[l][s] <= quo_in[l][s];
            end
         end
      end
   end

   always_comb begin
      out.valid = valid_ff[STAGES-1];
      out.x = nx_ff[STAGES-1] ? -$signed(PX_W'(quo_ff[0][STAGES-1]))
                              : $signed(PX_W'(quo_ff[0][STAGES-1]));
      out.y = ny_ff[STAGES-1] ? -$signed(PX_W'(quo_ff[1][STAGES-1]))
                              : $signed(PX_W'(quo_ff[1][STAGES-1]));
      out.z = quo_ff[2][STAGES-1];
   end

endmodule

>>> design/depth_pixel_backprojection_top.sv
// channel  direction  handshake                 payload
// req      in         req_tvalid / req_tready   tdata: col, row, depth; tuser: mask_set
// rsp      out        rsp_tvalid / rsp_tready   tdata: point_x, point_y, point_z
// csr      in         csr_valid / csr_ready     csr_index, csr_data
//
// one pixel per cycle while the rsp word is not stalled; the pipeline is made of
// the bit-per-stage slope dividers (32), square root (34),
// coordinate dividers (26) and the output register (1)
// reset clears all valid bits and loads the default intrinsics
// a stalled rsp word freezes the whole pipeline; req_tready drops in the same cycle
// masked or out-of-frame pixels flow through as bubbles and give no word
module depth_pixel_backprojection_top
   import dfb_pkg::*;
#(
   parameter int MAX_COLUMNS = 4096,
   parameter int MAX_ROWS = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // pixel_col, pixel_row, depth
   input  logic                  req_tuser,  // mask_set
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // point_x, point_y, point_z, zero pad
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [REG_W-1:0]      csr_data
);

   localparam int LIM_W = 17;

   logic [REG_W-1:0] focal_x_ff;
   logic [REG_W-1:0] focal_y_ff;
   logic [REG_W-1:0] center_x_ff;
   logic [REG_W-1:0] center_y_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   logic               en;
   logic               in_valid;
   logic [COORD_W-1:0] pixel_col;
   logic [COORD_W-1:0] pixel_row;
   logic [DEPTH_W-1:0] depth;
   slope_out_type      slope_out;
   root_out_type       root_out;
   point_type          point;

   assign pixel_col = req_tdata[COORD_W-1:0];
   assign pixel_row = req_tdata[2*COORD_W-1:COORD_W];
   assign depth = req_tdata[2*COORD_W+DEPTH_W-1:2*COORD_W];

   assign en = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign csr_ready = 1'b1;
   assign in_valid = req_tvalid && req_tuser
                  && (LIM_W'(pixel_col) < LIM_W'(MAX_COLUMNS))
                  && (LIM_W'(pixel_row) < LIM_W'(MAX_ROWS));

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff <= FOCAL_X_RESET;
         focal_y_ff <= FOCAL_Y_RESET;
         center_x_ff <= CENTER_X_RESET;
         center_y_ff <= CENTER_Y_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FOCAL_X: focal_x_ff <= csr_data;
            CSR_FOCAL_Y: focal_y_ff <= csr_data;
            CSR_CENTER_X: center_x_ff <= csr_data;
            CSR_CENTER_Y: center_y_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   dfb_slope u_slope (
      .clock(clock), .reset(reset), .en(en), .in_valid(in_valid),
      .pixel_col(pixel_col), .pixel_row(pixel_row), .depth(depth),
      .focal_x(focal_x_ff), .focal_y(focal_y_ff),
      .center_x(center_x_ff), .center_y(center_y_ff),
      .out(slope_out)
   );

   dfb_root u_root (
      .clock(clock), .reset(reset), .en(en), .in(slope_out), .out(root_out)
   );

   dfb_scale u_scale (
      .clock(clock), .reset(reset), .en(en), .in(root_out), .out(point)
   );

   always_comb begin
      rsp_valid_in = en ? point.valid : rsp_valid_ff;
      rsp_data_in = en ? RSP_DATA_W'({point.z, point.y, point.x}) : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule

>>> design/dfb_checker.sv
module dfb_checker
   import dfb_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int USED_W = 2 * PX_W + PZ_W;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   a_ready_follows_space: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req_tready does not track output space");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp word after reset");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:USED_W] == '0)
      else $error("rsp pad bits not zero");

endmodule

bind depth_pixel_backprojection_top dfb_checker u_checker (
   .clock(clock),
   .reset(reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
   import dfb_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 120;

   typedef struct {
      logic [11:0] col;
      logic [11:0] row;
      logic [15:0] depth;
      logic        mask;
   } pixel_item_type;

   typedef struct {
      logic [24:0] x;
      logic [24:0] y;
      logic [23:0] z;
   } point_item_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [REG_W-1:0]      csr_data;

   pixel_item_type pixel_q[$];
   point_item_type point_q[$];
   pixel_item_type cur_pixel;
   logic [19:0] focal_x, focal_y, center_x, center_y;
   int  mismatches = 0;
   int  req_gap = 0;
   int  rsp_gap = 0;
   int  cycles = 0;
   bit  quiet = 0;

   depth_pixel_backprojection_top u_top (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic void ray_slope(input logic [11:0] pix, input logic [19:0] center,
                                     input logic [19:0] focal,
                                     output longint unsigned mag, output bit neg);
      longint unsigned p;
      longint unsigned f;
      longint unsigned off;
      p = longint'(pix) << 8;
      f = (focal == 0) ? 1 : focal;
      if (p >= center) begin
         off = p - center;
         neg = 0;
      end else begin
         off = center - p;
         neg = 1;
      end
      mag = (off << 16) / f;
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      if (mag == 0) neg = 0;
   endfunction

   function automatic logic [24:0] scaled_coord(longint unsigned depth, longint unsigned mag,
                                                bit neg, longint unsigned r);
      longint unsigned q;
      q = (depth * mag * 256 + (r >> 1)) / r;
      if (neg) begin
         if (q > 16777216) q = 16777216;
         return 25'(-q);
      end
      if (q > 16777215) q = 16777215;
      return 25'(q);
   endfunction

   function automatic void project_pixel(pixel_item_type px);
      longint unsigned ux, vy, r, z;
      bit nx, ny;
      point_item_type pt;
      if (!px.mask) return;
      ray_slope(px.col, center_x, focal_x, ux, nx);
      ray_slope(px.row, center_y, focal_y, vy, ny);
      r = root_floor(ux * ux + vy * vy + (64'd1 << 32));
      z = ((longint'(px.depth) << 24) + (r >> 1)) / r;
      if (z > 16777215) z = 16777215;
      pt.x = scaled_coord(px.depth, ux, nx, r);
      pt.y = scaled_coord(px.depth, vy, ny, r);
      pt.z = 24'(z);
      point_q = {point_q, pt};
   endfunction

   function automatic logic [19:0] pick_field(logic [19:0] lo);
      case ($urandom_range(0, 5))
         0: return lo;
         1: return 20'hFFFFF;
         default: return 20'($urandom);
      endcase
   endfunction

   function automatic pixel_item_type random_pixel();
      pixel_item_type px;
      px.col = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 12'hFFF : 12'h0)
                                           : 12'($urandom);
      px.row = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 12'hFFF : 12'h0)
                                           : 12'($urandom);
      case ($urandom_range(0, 9))
         0: px.depth = 16'h0;
         1: px.depth = 16'hFFFF;
         default: px.depth = 16'($urandom);
      endcase
      px.mask = ($urandom_range(0, 4) != 0);
      return px;
   endfunction

   // intrinsics shadow
   always @(posedge clock) begin
      if (reset) begin
         focal_x <= FOCAL_X_RESET;
         focal_y <= FOCAL_Y_RESET;
         center_x <= CENTER_X_RESET;
         center_y <= CENTER_Y_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FOCAL_X:  focal_x <= csr_data;
            CSR_FOCAL_Y:  focal_y <= csr_data;
            CSR_CENTER_X: center_x <= csr_data;
            CSR_CENTER_Y: center_y <= csr_data;
            default: ;
         endcase
      end
   end

   // pixel driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) project_pixel(cur_pixel);
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
               req_gap = $urandom_range(0, 10);
               req_tvalid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
               cur_pixel = pixel_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {cur_pixel.depth, cur_pixel.row, cur_pixel.col};
               req_tuser <= cur_pixel.mask;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // point monitor
   always @(posedge clock) begin
      point_item_type exp_pt;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (point_q.size() == 0) begin
               if (mismatches < 10) $display("unexpected point word %h", rsp_tdata);
               mismatches++;
            end else begin
               exp_pt = point_q.pop_front();
               if (rsp_tdata[24:0] !== exp_pt.x || rsp_tdata[49:25] !== exp_pt.y ||
                   rsp_tdata[73:50] !== exp_pt.z) begin
                  if (mismatches < 10)
                     $display("point mismatch: expected x=%h y=%h z=%h, got x=%h y=%h z=%h",
                              exp_pt.x, exp_pt.y, exp_pt.z,
                              rsp_tdata[24:0], rsp_tdata[49:25], rsp_tdata[73:50]);
                  mismatches++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            rsp_gap = $urandom_range(0, 10);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [REG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_intrinsics(logic [19:0] fx, logic [19:0] fy,
                                 logic [19:0] cx, logic [19:0] cy);
      write_reg(CSR_FOCAL_X, fx);
      write_reg(CSR_FOCAL_Y, fy);
      write_reg(CSR_CENTER_X, cx);
      write_reg(CSR_CENTER_Y, cy);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(negedge clock); while (pixel_q.size() > 0 || req_tvalid || point_q.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic push_pixel(int col, int row, int depth, bit mask);
      pixel_item_type px;
      px.col = 12'(col);
      px.row = 12'(row);
      px.depth = 16'(depth);
      px.mask = mask;
      pixel_q = {pixel_q, px};
   endtask

   task automatic push_random(int n);
      repeat (n) pixel_q = {pixel_q, random_pixel()};
   endtask

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults, field corners
      push_pixel(320, 240, 1000, 1);
      push_pixel(0, 0, 65535, 1);
      push_pixel(4095, 4095, 65535, 1);
      push_pixel(4095, 0, 1, 1);
      push_pixel(0, 4095, 0, 1);
      push_pixel(100, 200, 500, 0);
      push_pixel(4095, 4095, 65535, 0);
      push_pixel(321, 239, 65535, 1);
      wait_idle();

      // zero focal length, slopes saturate
      set_intrinsics(20'h0, 20'h0, 20'hFFFFF, 20'h0);
      push_pixel(0, 4095, 65535, 1);
      push_pixel(4095, 0, 65535, 1);
      push_pixel(0, 0, 12345, 1);
      wait_idle();

      // focal of 256, principal point at origin
      set_intrinsics(20'd256, 20'd256, 20'h0, 20'h0);
      push_pixel(4095, 4095, 65535, 1);
      push_pixel(0, 0, 65535, 1);
      push_pixel(1, 0, 7, 1);
      wait_idle();

      // largest focal, unused register index ignored
      set_intrinsics(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
      write_reg(CSR_UNUSED, 20'h00100);
      csr_valid <= 1'b0;
      push_pixel(0, 0, 65535, 1);
      push_pixel(4095, 4095, 65535, 1);
      push_pixel(2048, 1024, 0, 1);
      wait_idle();

      repeat (8) begin
         set_intrinsics(pick_field(20'd256), pick_field(20'd256),
                        pick_field(20'd0), pick_field(20'd0));
         push_random(70);
         wait_idle();
      end

      set_intrinsics(FOCAL_X_RESET, FOCAL_Y_RESET, CENTER_X_RESET, CENTER_Y_RESET);
      quiet = 1;
      push_random(60);
      wait_idle();

      if (mismatches == 0 && point_q.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> depth_pixel_backprojection_top.f
design/dfb_pkg.sv
design/dfb_slope.sv
design/dfb_root.sv
design/dfb_scale.sv
design/depth_pixel_backprojection_top.sv
design/dfb_checker.sv
bench/tb.sv
